[rtl/core/ftr_pkg.sv]
package ftr_pkg;

    // Channel count and field widths
    localparam int CHANNELS  = 2;
    localparam int KIND_W    = 2;
    localparam int CH_W      = 1;
    localparam int FRAG_W    = 16;
    localparam int COUNT_W   = 16;
    localparam int RPM_W     = 32;
    localparam int TPM_W     = 16;
    localparam int RATIO_W   = 8;
    localparam int LIMIT_W   = 16;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    // Milliseconds per second, walked through one bit a cycle
    localparam int              K_W      = 10;
    localparam logic [K_W-1:0]  MS_PER_S = 10'd1000;

    // Datapath widths of the rpm calculation
    localparam int P1_W      = TPM_W + RATIO_W;        // ticks_per_ms * ratio
    localparam int NUM_W     = P1_W + K_W;             // full numerator
    localparam int DEN_W     = COUNT_W + TPM_W + 1;    // count * tpm + fragment
    localparam int MUL_STEPS = RATIO_W + K_W;          // covers COUNT_W + 1 as well
    localparam int DIV_STEPS = NUM_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    // Register reset values
    localparam logic [TPM_W-1:0]   TPM_RST   = 16'd10000;
    localparam logic [RATIO_W-1:0] RATIO_RST = 8'd30;
    localparam logic [LIMIT_W-1:0] LIMIT_RST = 16'd100;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TPM   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RATIO = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT = 2'd2;

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_EDGE  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TICK  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CHECK = 2'd2;

    // Request handed to the rpm unit
    typedef struct packed {
        logic [TPM_W-1:0]   tpm;
        logic [RATIO_W-1:0] ratio;
        logic [COUNT_W-1:0] count;
        logic [FRAG_W-1:0]  frag;
    } t_calc_req;

endpackage

[rtl/core/ftr_rpm_calc.sv]
module ftr_rpm_calc (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  ftr_pkg::t_calc_req i_req,
    output logic              o_done,
    output logic [ftr_pkg::RPM_W-1:0] o_rpm
);
    import ftr_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_MUL  = 3'b010,
        ST_DIV  = 3'b100
    } t_state;

    t_state              r_state, n_state;
    logic [STEP_W-1:0]   r_step, n_step;
    logic                r_done, n_done;
    logic [TPM_W-1:0]    r_tpm, n_tpm;
    logic [FRAG_W-1:0]   r_frag, n_frag;
    logic [COUNT_W-1:0]  r_cnt_sh, n_cnt_sh;
    logic [RATIO_W-1:0]  r_ratio_sh, n_ratio_sh;
    logic [K_W-1:0]      r_k_sh, n_k_sh;
    logic [P1_W-1:0]     r_p1, n_p1;
    logic [NUM_W-1:0]    r_num, n_num;
    logic [DEN_W-1:0]    r_den, n_den;
    logic [DEN_W-1:0]    r_rem, n_rem;
    logic [DEN_W:0]      trial;
    logic                fits;

    // One restoring divide step: bring down the next numerator bit
    assign trial = {r_rem, r_num[NUM_W-1]};
    assign fits  = (trial >= {1'b0, r_den});

    // Shift-add multiplies, MSB first, then a bit-serial restoring divide
    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        n_done     = 1'b0;
        n_tpm      = r_tpm;
        n_frag     = r_frag;
        n_cnt_sh   = r_cnt_sh;
        n_ratio_sh = r_ratio_sh;
        n_k_sh     = r_k_sh;
        n_p1       = r_p1;
        n_num      = r_num;
        n_den      = r_den;
        n_rem      = r_rem;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_tpm      = i_req.tpm;
                    n_frag     = i_req.frag;
                    n_cnt_sh   = i_req.count;
                    n_ratio_sh = i_req.ratio;
                    n_k_sh     = MS_PER_S;
                    n_p1       = '0;
                    n_num      = '0;
                    n_den      = '0;
                    n_step     = '0;
                    n_state    = ST_MUL;
                end
            end
            ST_MUL: begin
                // divisor: count * tpm, then the fragment on top
                if (r_step < STEP_W'(COUNT_W)) begin
                    n_den    = {r_den[DEN_W-2:0], 1'b0}
                             + (r_cnt_sh[COUNT_W-1] ? DEN_W'(r_tpm) : '0);
                    n_cnt_sh = {r_cnt_sh[COUNT_W-2:0], 1'b0};
                end else if (r_step == STEP_W'(COUNT_W)) begin
                    n_den = r_den + DEN_W'(r_frag);
                end
                // numerator: tpm * ratio, then that times 1000
                if (r_step < STEP_W'(RATIO_W)) begin
                    n_p1       = {r_p1[P1_W-2:0], 1'b0}
                               + (r_ratio_sh[RATIO_W-1] ? P1_W'(r_tpm) : '0);
                    n_ratio_sh = {r_ratio_sh[RATIO_W-2:0], 1'b0};
                end else begin
                    n_num  = {r_num[NUM_W-2:0], 1'b0}
                           + (r_k_sh[K_W-1] ? NUM_W'(r_p1) : '0);
                    n_k_sh = {r_k_sh[K_W-2:0], 1'b0};
                end
                if (r_step == STEP_W'(MUL_STEPS - 1)) begin
                    n_step  = '0;
                    n_rem   = '0;
                    n_state = ST_DIV;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            ST_DIV: begin
                // quotient bits shift in behind the numerator
                n_rem = fits ? DEN_W'(trial - {1'b0, r_den}) : trial[DEN_W-1:0];
                n_num = {r_num[NUM_W-2:0], fits};
                if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                    n_done  = 1'b1;
                    n_state = ST_IDLE;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tpm      <= n_tpm;
        r_frag     <= n_frag;
        r_cnt_sh   <= n_cnt_sh;
        r_ratio_sh <= n_ratio_sh;
        r_k_sh     <= n_k_sh;
        r_p1       <= n_p1;
        r_num      <= n_num;
        r_den      <= n_den;
        r_rem      <= n_rem;
    end

    // Saturate to 32 bits; a zero divisor yields all ones on its own
    assign o_done = r_done;
    assign o_rpm  = (|r_num[NUM_W-1:RPM_W]) ? '1 : r_num[RPM_W-1:0];

endmodule

[rtl/core/fan_tach_period_to_rpm_core.sv]
// Two-channel fan tachometer: turns tach periods into rpm.
// Input items (i_valid / o_stall) carry a kind, a channel and a fine-timer
// fragment. Kind 0 is a tach edge, kind 1 a millisecond tick, kind 2 a
// timeout check. Every item yields exactly one result item (o_valid /
// i_stall) with the channel's rpm, running flag and timeout flag.
// Ticks, checks and unused kinds finish at acceptance: the result is
// presented on the next cycle when the output is free. A tach edge runs a
// shift-add multiply and then a restoring divide, one quotient bit a cycle,
// and no further item is taken until its result is registered into the
// output register or the holding register.
// The output register holds a result while the receiver stalls; one more
// item is still accepted and its result waits in a holding register, after
// which o_stall stays high until the output drains.
// The configuration port (i_cfg_we, i_cfg_idx, i_cfg_data) writes
// ticks_per_ms, pulses_rpm_ratio and timeout_limit; write only while idle.
// Reset (synchronous, active low) restores the default registers, clears
// every channel's count, rpm and running flag, and empties the output.
module fan_tach_period_to_rpm_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [ftr_pkg::KIND_W-1:0]    i_kind,
    input  logic [ftr_pkg::CH_W-1:0]      i_channel,
    input  logic [ftr_pkg::FRAG_W-1:0]    i_fragment,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [ftr_pkg::RPM_W-1:0]     o_rpm,
    output logic                          o_running,
    output logic                          o_timed_out,
    input  logic                          i_cfg_we,
    input  logic [ftr_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ftr_pkg::CFG_W-1:0]     i_cfg_data
);
    import ftr_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CALC = 3'b010,
        ST_HOLD = 3'b100
    } t_state;

    t_state              r_state, n_state;
    logic [TPM_W-1:0]    r_tpm;
    logic [RATIO_W-1:0]  r_ratio;
    logic [LIMIT_W-1:0]  r_limit;
    logic [COUNT_W-1:0]  r_count [CHANNELS];
    logic [COUNT_W-1:0]  n_count [CHANNELS];
    logic                r_run   [CHANNELS];
    logic                n_run   [CHANNELS];
    logic [RPM_W-1:0]    r_rpm   [CHANNELS];
    logic [RPM_W-1:0]    n_rpm   [CHANNELS];
    logic [CH_W-1:0]     r_ch, n_ch;

    logic                r_o_valid, n_o_valid;
    logic [RPM_W-1:0]    r_o_rpm, n_o_rpm;
    logic                r_o_run, n_o_run;
    logic                r_o_tout, n_o_tout;
    logic [RPM_W-1:0]    r_h_rpm, n_h_rpm;
    logic                r_h_run, n_h_run;
    logic                r_h_tout, n_h_tout;

    logic                accept;
    logic                present;
    logic                out_free;
    logic                calc_start;
    logic                calc_done;
    logic [RPM_W-1:0]    calc_rpm;
    t_calc_req           calc_req;
    logic [RPM_W-1:0]    res_rpm;
    logic                res_run;
    logic                res_tout;

    assign o_stall  = (r_state != ST_IDLE);
    assign accept   = i_valid && !o_stall;
    assign present  = (int'(i_channel) < CHANNELS);
    assign out_free = !r_o_valid || !i_stall;

    assign calc_req.tpm   = r_tpm;
    assign calc_req.ratio = r_ratio;
    assign calc_req.count = r_count[i_channel];
    assign calc_req.frag  = i_fragment;

    ftr_rpm_calc u_calc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (calc_start),
        .i_req   (calc_req),
        .o_done  (calc_done),
        .o_rpm   (calc_rpm)
    );

    // Channel state update and immediate result
    always_comb begin
        n_count    = r_count;
        n_run      = r_run;
        n_rpm      = r_rpm;
        calc_start = 1'b0;
        res_tout   = 1'b0;
        if (accept && present) begin
            case (i_kind)
                KIND_EDGE: begin
                    n_count[i_channel] = '0;
                    n_run[i_channel]   = 1'b1;
                    calc_start         = 1'b1;
                end
                KIND_TICK: begin
                    if (r_count[i_channel] != '1) begin
                        n_count[i_channel] = r_count[i_channel] + 1'b1;
                    end
                end
                KIND_CHECK: begin
                    if (!r_run[i_channel]) begin
                        res_tout = 1'b1;
                    end else if (r_count[i_channel] > r_limit) begin
                        n_count[i_channel] = '0;
                        n_run[i_channel]   = 1'b0;
                        n_rpm[i_channel]   = '0;
                        res_tout           = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
        // finished division lands in the channel it was started for
        if (calc_done) begin
            n_rpm[r_ch] = calc_rpm;
        end
        res_rpm = present ? n_rpm[i_channel] : '0;
        res_run = present ? n_run[i_channel] : 1'b0;
    end

    // Sequencing of items and results
    always_comb begin
        n_state   = r_state;
        n_ch      = r_ch;
        n_o_valid = r_o_valid && i_stall;
        n_o_rpm   = r_o_rpm;
        n_o_run   = r_o_run;
        n_o_tout  = r_o_tout;
        n_h_rpm   = r_h_rpm;
        n_h_run   = r_h_run;
        n_h_tout  = r_h_tout;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (calc_start) begin
                        n_ch    = i_channel;
                        n_state = ST_CALC;
                    end else if (out_free) begin
                        n_o_valid = 1'b1;
                        n_o_rpm   = res_rpm;
                        n_o_run   = res_run;
                        n_o_tout  = res_tout;
                    end else begin
                        n_h_rpm  = res_rpm;
                        n_h_run  = res_run;
                        n_h_tout = res_tout;
                        n_state  = ST_HOLD;
                    end
                end
            end
            ST_CALC: begin
                if (calc_done) begin
                    if (out_free) begin
                        n_o_valid = 1'b1;
                        n_o_rpm   = calc_rpm;
                        n_o_run   = 1'b1;
                        n_o_tout  = 1'b0;
                        n_state   = ST_IDLE;
                    end else begin
                        n_h_rpm  = calc_rpm;
                        n_h_run  = 1'b1;
                        n_h_tout = 1'b0;
                        n_state  = ST_HOLD;
                    end
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    n_o_valid = 1'b1;
                    n_o_rpm   = r_h_rpm;
                    n_o_run   = r_h_run;
                    n_o_tout  = r_h_tout;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control, configuration and channel state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_o_valid <= 1'b0;
            r_ch      <= '0;
            r_tpm     <= TPM_RST;
            r_ratio   <= RATIO_RST;
            r_limit   <= LIMIT_RST;
            for (int i = 0; i < CHANNELS; i++) begin
                r_count[i] <= '0;
                r_run[i]   <= 1'b0;
                r_rpm[i]   <= '0;
            end
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
            r_ch      <= n_ch;
            r_count   <= n_count;
            r_run     <= n_run;
            r_rpm     <= n_rpm;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_TPM:   r_tpm   <= i_cfg_data[TPM_W-1:0];
                    REG_RATIO: r_ratio <= i_cfg_data[RATIO_W-1:0];
                    REG_LIMIT: r_limit <= i_cfg_data[LIMIT_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        r_o_rpm  <= n_o_rpm;
        r_o_run  <= n_o_run;
        r_o_tout <= n_o_tout;
        r_h_rpm  <= n_h_rpm;
        r_h_run  <= n_h_run;
        r_h_tout <= n_h_tout;
    end

    assign o_valid     = r_o_valid;
    assign o_rpm       = r_o_rpm;
    assign o_running   = r_o_run;
    assign o_timed_out = r_o_tout;

endmodule

[sim/rpm_checker.sv]
`timescale 1ns / 1ps

// Watches both item channels and the register port of the fan tachometer,
// keeps its own copy of each fan's state and checks every result item.
module rpm_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  logic [ftr_pkg::KIND_W-1:0]    i_kind,
    input  logic [ftr_pkg::CH_W-1:0]      i_channel,
    input  logic [ftr_pkg::FRAG_W-1:0]    i_fragment,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  logic [ftr_pkg::RPM_W-1:0]     i_rpm,
    input  logic                          i_running,
    input  logic                          i_timed_out,
    input  logic                          i_cfg_we,
    input  logic [ftr_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ftr_pkg::CFG_W-1:0]     i_cfg_data,
    output int                            o_fail_count,
    output int                            o_pending
);
    import ftr_pkg::*;

    localparam int MAX_REPORTS = 40;

    typedef struct packed {
        logic [RPM_W-1:0] rpm;
        logic             running;
        logic             timed_out;
    } t_fan_status;

    // Expected results, oldest first
    t_fan_status status_q[$];

    // Shadow registers and per-fan state
    logic [TPM_W-1:0]   tpm;
    logic [RATIO_W-1:0] ratio;
    logic [LIMIT_W-1:0] limit;
    logic [COUNT_W-1:0] ms_count [CHANNELS];
    logic               fan_on   [CHANNELS];
    logic [RPM_W-1:0]   fan_rpm  [CHANNELS];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        o_fail_count++;
        if (o_fail_count <= MAX_REPORTS) begin
            $display("[%0t] rpm mismatch: %s got 0x%0h want 0x%0h", $time, what, got, want);
        end
    endtask

    // rpm from the elapsed period; zero period and oversize quotients saturate
    function automatic logic [RPM_W-1:0] period_rpm(input logic [COUNT_W-1:0] count,
                                                    input logic [FRAG_W-1:0] frag);
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] quot;
        num = 64'(tpm) * 64'(MS_PER_S) * 64'(ratio);
        den = 64'(count) * 64'(tpm) + 64'(frag);
        if (den == 64'd0) return '1;
        quot = num / den;
        if (quot > 64'hFFFF_FFFF) return '1;
        return quot[RPM_W-1:0];
    endfunction

    // Apply one item to the fan state and give the status it reports
    function automatic t_fan_status step_fan(input logic [KIND_W-1:0] kind,
                                             input int unsigned ch,
                                             input logic [FRAG_W-1:0] frag);
        t_fan_status res;
        res = '0;
        if (ch >= CHANNELS) return res;
        case (kind)
            KIND_EDGE: begin
                fan_rpm[ch]  = period_rpm(ms_count[ch], frag);
                ms_count[ch] = '0;
                fan_on[ch]   = 1'b1;
            end
            KIND_TICK: begin
                if (ms_count[ch] != '1) ms_count[ch] = ms_count[ch] + 1'b1;
            end
            KIND_CHECK: begin
                if (!fan_on[ch]) begin
                    res.timed_out = 1'b1;
                end else if (ms_count[ch] > limit) begin
                    // stale fan: forget it
                    fan_on[ch]    = 1'b0;
                    ms_count[ch]  = '0;
                    fan_rpm[ch]   = '0;
                    res.timed_out = 1'b1;
                end
            end
            default: ;
        endcase
        res.rpm     = fan_rpm[ch];
        res.running = fan_on[ch];
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_fan_status want;
        if (!i_rst_n) begin
            tpm   = TPM_RST;
            ratio = RATIO_RST;
            limit = LIMIT_RST;
            for (int c = 0; c < CHANNELS; c++) begin
                ms_count[c] = '0;
                fan_on[c]   = 1'b0;
                fan_rpm[c]  = '0;
            end
            status_q.delete();
        end else begin
            // result side first: it can only belong to an earlier item
            if (i_out_valid && !i_out_stall) begin
                if (status_q.size() == 0) begin
                    report_mismatch("result with no item waiting, rpm", 64'(i_rpm), 64'd0);
                end else begin
                    want = status_q.pop_front();
                    if (i_rpm !== want.rpm)
                        report_mismatch("rpm", 64'(i_rpm), 64'(want.rpm));
                    if (i_running !== want.running)
                        report_mismatch("running", 64'(i_running), 64'(want.running));
                    if (i_timed_out !== want.timed_out)
                        report_mismatch("timed_out", 64'(i_timed_out), 64'(want.timed_out));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                status_q.push_back(step_fan(i_kind, i_channel, i_fragment));
            end
            // register writes, kept within each register's width
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_TPM:   tpm   = i_cfg_data[TPM_W-1:0];
                    REG_RATIO: ratio = i_cfg_data[RATIO_W-1:0];
                    REG_LIMIT: limit = i_cfg_data[LIMIT_W-1:0];
                    default: ;
                endcase
            end
        end
        o_pending = status_q.size();
    end

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import ftr_pkg::*;

    localparam logic [KIND_W-1:0]    KIND_SPARE   = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE    = 2'd3;
    localparam int                   PHASE_ITEMS  = 300;
    localparam int                   LONG_TICKS   = 400;
    localparam int                   HOLD_CYCLES  = 300;
    localparam int                   DRAIN_CYCLES = 64;

    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 i_valid    = 1'b0;
    logic                 o_stall;
    logic [KIND_W-1:0]    i_kind     = '0;
    logic [CH_W-1:0]      i_channel  = '0;
    logic [FRAG_W-1:0]    i_fragment = '0;
    logic                 o_valid;
    logic                 i_stall    = 1'b0;
    logic [RPM_W-1:0]     o_rpm;
    logic                 o_running;
    logic                 o_timed_out;
    logic                 i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx  = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;

    int fail_count;
    int pending;

    // Stimulus bookkeeping
    logic [TPM_W-1:0]   cur_tpm   = TPM_RST;
    logic [LIMIT_W-1:0] cur_limit = LIMIT_RST;
    int  items_by_kind [4] = '{0, 0, 0, 0};
    int  n_settings = 1;
    int  burst_left = 0;
    bit  use_gaps   = 1'b1;
    bit  hold_req   = 1'b0;
    int  hold_count = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    fan_tach_period_to_rpm_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_kind      (i_kind),
        .i_channel   (i_channel),
        .i_fragment  (i_fragment),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_rpm       (o_rpm),
        .o_running   (o_running),
        .o_timed_out (o_timed_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    rpm_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_stall   (o_stall),
        .i_kind       (i_kind),
        .i_channel    (i_channel),
        .i_fragment   (i_fragment),
        .i_out_valid  (o_valid),
        .i_out_stall  (i_stall),
        .i_rpm        (o_rpm),
        .i_running    (o_running),
        .i_timed_out  (o_timed_out),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Offer one item from a falling edge and hold it until taken; returns on a
    // falling edge with valid still high so the next item can follow at once
    task automatic send_item(input logic [KIND_W-1:0] kind, input logic [CH_W-1:0] ch,
                             input logic [FRAG_W-1:0] frag);
        bit taken;
        if (use_gaps) begin
            if (burst_left == 0) begin
                i_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge i_clk);
                burst_left = $urandom_range(1, 32);
            end
            burst_left--;
        end
        i_valid    <= 1'b1;
        i_kind     <= kind;
        i_channel  <= ch;
        i_fragment <= frag;
        items_by_kind[kind]++;
        taken = 1'b0;
        while (!taken) begin
            @(posedge i_clk);
            taken = !o_stall;
            @(negedge i_clk);
        end
    endtask

    // Stop offering and wait for every outstanding result
    task automatic settle();
        i_valid <= 1'b0;
        @(negedge i_clk);
        wait (pending == 0);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
        if (idx == REG_TPM) cur_tpm = data[TPM_W-1:0];
        if (idx == REG_LIMIT) cur_limit = data[LIMIT_W-1:0];
    endtask

    task automatic set_regs(input logic [CFG_W-1:0] tpm_v, input logic [CFG_W-1:0] ratio_v,
                            input logic [CFG_W-1:0] limit_v);
        write_reg(REG_TPM, tpm_v);
        write_reg(REG_RATIO, ratio_v);
        write_reg(REG_LIMIT, limit_v);
        n_settings++;
    endtask

    // Fine-timer fragment that a real edge would carry: mostly below ticks_per_ms, else any value
    function automatic logic [FRAG_W-1:0] edge_fragment();
        if (cur_tpm == '0 || $urandom_range(0, 3) == 0) return FRAG_W'($urandom);
        return FRAG_W'($urandom_range(0, int'(cur_tpm) - 1));
    endfunction

    // Mostly tick runs closed by an edge, with checks in between; some noise
    task automatic run_phase(input bit do_hold);
        int sent;
        int hi;
        int hold_at;
        logic [CH_W-1:0] ch;
        sent    = 0;
        hold_at = do_hold ? PHASE_ITEMS / 2 : -1;
        while (sent < PHASE_ITEMS) begin
            if (hold_at >= 0 && sent >= hold_at) begin
                hold_req = 1'b1;
                hold_at  = -1;
            end
            if ($urandom_range(0, 9) < 8) begin
                ch = CH_W'($urandom_range(0, CHANNELS - 1));
                hi = (int'(cur_limit) < 40) ? int'(cur_limit) + 2 : 40;
                if ($urandom_range(0, 7) == 0)
                    hi = (int'(cur_limit) < 148) ? int'(cur_limit) + 2 : 150;
                repeat ($urandom_range(0, hi)) begin
                    send_item(KIND_TICK, ch, FRAG_W'($urandom));
                    sent++;
                end
                if ($urandom_range(0, 2) == 0) begin
                    send_item(KIND_CHECK, ch, FRAG_W'($urandom));
                    sent++;
                end
                send_item(KIND_EDGE, ch, edge_fragment());
                sent++;
                if ($urandom_range(0, 1) == 0) begin
                    send_item(KIND_CHECK, ch, FRAG_W'($urandom));
                    sent++;
                end
            end else begin
                send_item(KIND_W'($urandom_range(0, 3)), CH_W'($urandom),
                          FRAG_W'($urandom));
                sent++;
            end
        end
    endtask

    // Receiver: random stall runs, long free runs, and a long hold on request
    initial begin
        int  rx_run;
        logic rx_stalled;
        int  pick;
        rx_run     = 0;
        rx_stalled = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_count++;
                hold_req = 1'b0;
                i_stall <= 1'b0;
            end else begin
                if (rx_run == 0) begin
                    pick = $urandom_range(0, 9);
                    rx_stalled = (pick < 3);
                    if (pick < 3)      rx_run = $urandom_range(1, 6);
                    else if (pick < 9) rx_run = $urandom_range(1, 8);
                    else               rx_run = $urandom_range(40, 80);
                end
                rx_run--;
                i_stall <= rx_stalled;
            end
        end
    end

    // Watchdog
    initial begin
        #10_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: idle check, zero period, normal edge, unused kind
        send_item(KIND_CHECK, 1'b0, 16'h0000);
        send_item(KIND_EDGE, 1'b0, 16'h0000);
        send_item(KIND_TICK, 1'b0, 16'hFFFF);
        send_item(KIND_TICK, 1'b0, 16'h5A5A);
        send_item(KIND_EDGE, 1'b0, 16'd5000);
        send_item(KIND_CHECK, 1'b0, 16'hFFFF);
        send_item(KIND_SPARE, 1'b1, 16'hA5A5);
        send_item(KIND_EDGE, 1'b1, 16'hFFFF);
        send_item(KIND_SPARE, 1'b0, 16'h0000);
        settle();

        // Largest numerator over a one-tick period overflows 32 bits; stale fans
        set_regs(16'hFFFF, 16'hFFFF, 16'h0000);
        write_reg(REG_SPARE, 16'h1234);
        send_item(KIND_EDGE, 1'b1, 16'h0001);
        send_item(KIND_TICK, 1'b0, 16'h0000);
        send_item(KIND_CHECK, 1'b0, 16'h0000);
        send_item(KIND_CHECK, 1'b0, 16'h0000);
        send_item(KIND_TICK, 1'b1, 16'h0000);
        send_item(KIND_CHECK, 1'b1, 16'hFFFF);
        settle();

        // Zero ticks_per_ms and zero ratio as written
        set_regs(16'h0000, 16'h0100, 16'd5);
        send_item(KIND_EDGE, 1'b0, 16'h0000);
        send_item(KIND_TICK, 1'b0, 16'h0000);
        send_item(KIND_EDGE, 1'b0, 16'h0007);
        settle();

        // A long back-to-back tick run on one fan, then the longest fragment
        set_regs(16'hFFFF, 16'h00FF, 16'hFFFF);
        use_gaps = 1'b0;
        send_item(KIND_EDGE, 1'b1, 16'd100);
        repeat (LONG_TICKS) send_item(KIND_TICK, 1'b1, FRAG_W'($urandom));
        send_item(KIND_CHECK, 1'b1, 16'h0000);
        send_item(KIND_EDGE, 1'b1, 16'hFFFF);
        use_gaps = 1'b1;
        settle();

        // Random phases over several register settings
        set_regs(TPM_RST, RATIO_RST, LIMIT_RST);
        run_phase(1'b0);
        settle();
        set_regs(16'd1, 16'd1, 16'd0);
        run_phase(1'b1);
        settle();
        set_regs(16'hFFFF, 16'h00FF, 16'hFFFF);
        run_phase(1'b0);
        settle();
        set_regs(CFG_W'($urandom_range(1, 65535)), CFG_W'($urandom_range(1, 255)),
                 CFG_W'($urandom_range(0, 60)));
        run_phase(1'b1);
        settle();
        set_regs(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom_range(0, 20)));
        run_phase(1'b0);
        settle();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Covered %0d edges, %0d ticks, %0d checks and %0d unused-kind items",
                 items_by_kind[KIND_EDGE], items_by_kind[KIND_TICK],
                 items_by_kind[KIND_CHECK], items_by_kind[KIND_SPARE]);
        $display("over %0d register settings, with %0d long receiver hold-offs",
                 n_settings, hold_count);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
